// ===== rtl/pspc_pkg.sv =====
package pspc_pkg;

   // field widths
   localparam int PidWidth = 13;
   localparam int MapBitBits = 5;
   localparam int MapRowBits = PidWidth - MapBitBits;
   localparam int MapRowWidth = 1 << MapBitBits;
   localparam int LenWidth = 12;
   localparam int CsrIndexWidth = 8;

   // default depth of the queue between parser and map stage
   localparam int QueueDepth = 4;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_ENABLE = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WANT_TELETEXT = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_WANT_SUBTITLES = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_WANT_DSMCC = 8'd3;

   // stream types of interest
   localparam logic [7:0] STREAM_PRIVATE_PES = 8'h06;
   localparam logic [7:0] STREAM_DSMCC_A = 8'h0b;
   localparam logic [7:0] STREAM_DSMCC_B = 8'h0c;
   localparam logic [7:0] STREAM_DSMCC_C = 8'h0d;

   typedef struct packed {
      logic enable;
      logic want_teletext;
      logic want_subtitles;
      logic want_dsmcc;
   } cfg_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic last_byte;
   } req_type;

   typedef struct packed {
      logic new_pid_valid;
      logic [PidWidth-1:0] new_pid;
      logic section_done;
      logic any_new;
      logic truncated;
   } rsp_type;

   // one classified byte handed from the parser to the map stage
   typedef struct packed {
      logic pid_check;
      logic [PidWidth-1:0] pid;
      logic last;
      logic trunc;
   } op_type;

endpackage

// ===== rtl/pspc_front.sv =====
module pspc_front (
   input logic clock,
   input logic reset,
   input logic accept,
   input pspc_pkg::req_type req_data,
   input pspc_pkg::cfg_type cfg,
   output pspc_pkg::op_type op
);
   import pspc_pkg::*;

   typedef enum logic [10:0] {
      PH_PCR_HI    = 11'b000_0000_0001,
      PH_PCR_LO    = 11'b000_0000_0010,
      PH_PI_LEN_HI = 11'b000_0000_0100,
      PH_PI_LEN_LO = 11'b000_0000_1000,
      PH_PI_SKIP   = 11'b000_0001_0000,
      PH_ES_TYPE   = 11'b000_0010_0000,
      PH_PID_HI    = 11'b000_0100_0000,
      PH_PID_LO    = 11'b000_1000_0000,
      PH_ES_LEN_HI = 11'b001_0000_0000,
      PH_ES_LEN_LO = 11'b010_0000_0000,
      PH_ES_SKIP   = 11'b100_0000_0000
   } phase_type;

   phase_type phase_ff, phase_in, phase_step;
   logic [LenWidth-1:0] skip_ff, skip_in, skip_step, len_word;
   logic sel_ff, sel_in, sel_step;
   logic [PidWidth-9:0] pid_hi_ff, pid_hi_in, pid_hi_step;
   logic [7:0] b;
   logic type_hit;

   assign b = req_data.payload_byte;
   assign len_word = {skip_ff[LenWidth-1:8], b};

   // stream type selection from the current register values
   always_comb begin
      type_hit = 1'b0;
      if (b == STREAM_PRIVATE_PES) begin
         type_hit = cfg.want_teletext | cfg.want_subtitles;
      end else if (b == STREAM_DSMCC_A || b == STREAM_DSMCC_B || b == STREAM_DSMCC_C) begin
         type_hit = cfg.want_dsmcc;
      end
   end

   // parse step for one accepted byte
   always_comb begin
      phase_step = phase_ff;
      skip_step = skip_ff;
      sel_step = sel_ff;
      pid_hi_step = pid_hi_ff;
      unique case (phase_ff)
         PH_PCR_LO: begin
            phase_step = PH_PI_LEN_HI;
         end
         PH_PI_LEN_HI, PH_ES_LEN_HI: begin
            skip_step = {b[3:0], 8'h00};
            phase_step = (phase_ff == PH_PI_LEN_HI) ? PH_PI_LEN_LO : PH_ES_LEN_LO;
         end
         PH_PI_LEN_LO: begin
            skip_step = len_word;
            phase_step = (len_word != '0) ? PH_PI_SKIP : PH_ES_TYPE;
         end
         PH_ES_LEN_LO: begin
            skip_step = len_word;
            phase_step = (len_word != '0) ? PH_ES_SKIP : PH_ES_TYPE;
         end
         PH_PI_SKIP, PH_ES_SKIP: begin
            skip_step = skip_ff - 1'b1;
            if (skip_step == '0) begin
               phase_step = PH_ES_TYPE;
            end
         end
         PH_ES_TYPE: begin
            sel_step = cfg.enable & type_hit;
            phase_step = PH_PID_HI;
         end
         PH_PID_HI: begin
            pid_hi_step = b[4:0];
            phase_step = PH_PID_LO;
         end
         PH_PID_LO: begin
            sel_step = 1'b0;
            phase_step = PH_ES_LEN_HI;
         end
         default: begin
            phase_step = PH_PCR_LO;
         end
      endcase
   end

   // next state, with section end returning to the header
   always_comb begin
      phase_in = phase_ff;
      skip_in = skip_ff;
      sel_in = sel_ff;
      pid_hi_in = pid_hi_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            phase_in = PH_PCR_HI;
            skip_in = '0;
            sel_in = 1'b0;
            pid_hi_in = '0;
         end else begin
            phase_in = phase_step;
            skip_in = skip_step;
            sel_in = sel_step;
            pid_hi_in = pid_hi_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PCR_HI;
         skip_ff <= '0;
         sel_ff <= 1'b0;
         pid_hi_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         skip_ff <= skip_in;
         sel_ff <= sel_in;
         pid_hi_ff <= pid_hi_in;
      end
   end

   // classified byte for the map stage
   always_comb begin
      op.pid_check = (phase_ff == PH_PID_LO) && sel_ff;
      op.pid = {pid_hi_ff, b};
      op.last = req_data.last_byte;
      op.trunc = req_data.last_byte && (phase_step != PH_ES_TYPE);
   end

endmodule

// ===== rtl/pspc_queue.sv =====
module pspc_queue #(
   parameter int DEPTH = pspc_pkg::QueueDepth
) (
   input logic clock,
   input logic reset,
   input logic push,
   input pspc_pkg::op_type push_data,
   input logic pop,
   output pspc_pkg::op_type pop_data,
   output logic not_empty,
   output logic has_space
);
   import pspc_pkg::*;

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);

   op_type entries_ff [DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign has_space = (count_ff != CntBits'(DEPTH));
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pspc_back.sv =====
module pspc_back (
   input logic clock,
   input logic reset,
   input logic op_valid,
   input pspc_pkg::op_type op,
   output logic op_pop,
   output logic clearing,
   output logic rsp_valid,
   input logic rsp_ready,
   output pspc_pkg::rsp_type rsp_data
);
   import pspc_pkg::*;

   // seen map, one row of pid bits per word
   logic [MapRowWidth-1:0] map_mem [1 << MapRowBits];

   logic clr_active_ff, clr_active_in;
   logic [MapRowBits-1:0] clr_row_ff, clr_row_in;
   logic s1_valid_ff, s1_valid_in;
   op_type s1_op_ff;
   logic [MapRowWidth-1:0] row_data_ff;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic found_ff, found_in;
   logic s1_move, is_new;
   logic [MapRowBits-1:0] s1_row;
   logic [MapBitBits-1:0] s1_bit;

   assign s1_row = s1_op_ff.pid[PidWidth-1:MapBitBits];
   assign s1_bit = s1_op_ff.pid[MapBitBits-1:0];
   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign op_pop = op_valid && !clr_active_ff && (!s1_valid_ff || s1_move);
   assign is_new = s1_op_ff.pid_check && !row_data_ff[s1_bit];
   assign clearing = clr_active_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // clearing pass over the map rows after reset
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_row_in = clr_row_ff;
      if (clr_active_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == '1) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // lookup stage and result register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (op_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      found_in = found_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_in.new_pid_valid = is_new;
         out_in.new_pid = is_new ? s1_op_ff.pid : '0;
         out_in.section_done = s1_op_ff.last;
         out_in.any_new = s1_op_ff.last && (found_ff || is_new);
         out_in.truncated = s1_op_ff.trunc;
         found_in = s1_op_ff.last ? 1'b0 : (found_ff || is_new);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_row_ff <= clr_row_in;
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         found_ff <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (op_pop) begin
         s1_op_ff <= op;
      end
   end

   // map read on pop, write on clear or on a newly seen pid
   always_ff @(posedge clock) begin
      if (op_pop) begin
         row_data_ff <= map_mem[op.pid[PidWidth-1:MapBitBits]];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         map_mem[clr_row_ff] <= '0;
      end else if (s1_move && is_new) begin
         map_mem[s1_row] <= row_data_ff | (MapRowWidth'(1) << s1_bit);
      end
   end

   // no transfer reaches the map while it is being cleared
   assert property (@(posedge clock) disable iff (reset) clr_active_ff |-> !op_pop)
      else $error("pop during map clear");

   // section status only on the closing result
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.section_done |-> !out_ff.any_new && !out_ff.truncated)
      else $error("section status outside section end");

   // a reported pid always counts toward any_new at section end
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.new_pid_valid && out_ff.section_done |-> out_ff.any_new)
      else $error("new pid missing from any_new");

   // pid field is zero when nothing is reported
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.new_pid_valid |-> out_ff.new_pid == '0)
      else $error("stale pid on result");

endmodule

// ===== rtl/pmt_stream_pid_collector.sv =====
// PMT elementary stream pid collector.
// The req channel takes one PMT section payload byte per transfer, with
// last_byte set on the final byte. Every byte gives exactly one transfer on
// the rsp channel, in order: new_pid_valid/new_pid when the byte completes a
// selected stream entry whose pid was not seen before, and section_done,
// any_new and truncated on the closing byte.
// The csr channel writes enable, want_teletext, want_subtitles, want_dsmcc
// (indexes 0 to 3, bit 0 of the data); csr_ready is always high and writes to
// other indexes are dropped.
// Throughput is one byte per cycle while rsp_ready stays high; the result
// is registered in the queue, the lookup stage and the result register. The
// limit is the single read and single write per cycle of the seen-map memory
// (256 rows of 32 bits). After reset the map is cleared row by row with
// req_ready low; csr writes are taken meanwhile. The map is kept across sections.
// When the receiver stalls, the result register holds, the lookup stage and
// the parser queue fill up, and req_ready drops once the queue is full.
module pmt_stream_pid_collector #(
   parameter int QUEUE_DEPTH = pspc_pkg::QueueDepth
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input pspc_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output pspc_pkg::rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [pspc_pkg::CsrIndexWidth-1:0] csr_index,
   input logic [31:0] csr_data
);
   import pspc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type front_op, queue_op;
   logic req_fire, q_not_empty, q_space, q_pop, map_clearing;

   assign csr_ready = 1'b1;
   assign req_ready = q_space && !map_clearing;
   assign req_fire = req_valid && req_ready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE: cfg_in.enable = csr_data[0];
            CSR_WANT_TELETEXT: cfg_in.want_teletext = csr_data[0];
            CSR_WANT_SUBTITLES: cfg_in.want_subtitles = csr_data[0];
            CSR_WANT_DSMCC: cfg_in.want_dsmcc = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b1, want_teletext: 1'b0, want_subtitles: 1'b0,
                     want_dsmcc: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // byte parser
   pspc_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(req_fire),
      .req_data(req_data),
      .cfg(cfg_ff),
      .op(front_op)
   );

   // queue between parser and map stage
   pspc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(req_fire),
      .push_data(front_op),
      .pop(q_pop),
      .pop_data(queue_op),
      .not_empty(q_not_empty),
      .has_space(q_space)
   );

   // seen map lookup and result register
   pspc_back u_back (
      .clock(clock),
      .reset(reset),
      .op_valid(q_not_empty),
      .op(queue_op),
      .op_pop(q_pop),
      .clearing(map_clearing),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== test/pmt_stream_pid_collector_tb.sv =====
`timescale 1ns / 100ps

module pmt_stream_pid_collector_tb;
   import pspc_pkg::*;

   localparam int ItemTarget = 1270;
   localparam int QuietItems = 150;
   localparam int HoldCycles = 80;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles = 16;

   // parse positions inside a section
   typedef enum logic [3:0] {
      HDR_PCR_HI,
      HDR_PCR_LO,
      HDR_INFO_LEN_HI,
      HDR_INFO_LEN_LO,
      HDR_INFO_SKIP,
      ENT_TYPE,
      ENT_PID_HI,
      ENT_PID_LO,
      ENT_INFO_LEN_HI,
      ENT_INFO_LEN_LO,
      ENT_INFO_SKIP
   } parse_phase_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type item;
      logic [CsrIndexWidth-1:0] index;
      logic [31:0] wdata;
      logic checked;
      rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [31:0] csr_data;

   // predictor state
   cfg_type cfg;
   bit pid_seen [0:(1 << PidWidth) - 1];
   parse_phase_type cur_phase;
   logic [LenWidth-1:0] skip_left;
   logic entry_wanted;
   logic [4:0] pid_top;
   logic found_new;

   rsp_type awaited_rsp[$];
   stim_row_type directed_rows[$];
   req_type section_q[$];

   int error_count = 0;
   int items_sent = 0;
   int steady_items = 0;
   int idle_cycles;
   bit quiet_tail = 1'b0;
   bit rsp_hold_req = 1'b0;

   pmt_stream_pid_collector u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // stream type selection under the current register settings
   function automatic logic type_wanted(logic [7:0] stream_type);
      case (stream_type)
         STREAM_PRIVATE_PES: return cfg.want_teletext | cfg.want_subtitles;
         STREAM_DSMCC_A, STREAM_DSMCC_B, STREAM_DSMCC_C: return cfg.want_dsmcc;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void clear_section_state();
      cur_phase = HDR_PCR_HI;
      skip_left = '0;
      entry_wanted = 1'b0;
      pid_top = '0;
      found_new = 1'b0;
   endfunction

   // advance the parse by one payload byte and return the result it causes
   function automatic rsp_type parse_pmt_byte(req_type r);
      rsp_type o;
      logic [PidWidth-1:0] pid;
      o = '0;
      case (cur_phase)
         HDR_PCR_LO: cur_phase = HDR_INFO_LEN_HI;
         HDR_INFO_LEN_HI, ENT_INFO_LEN_HI: begin
            skip_left = {r.payload_byte[3:0], 8'h00};
            cur_phase = (cur_phase == HDR_INFO_LEN_HI) ? HDR_INFO_LEN_LO : ENT_INFO_LEN_LO;
         end
         HDR_INFO_LEN_LO: begin
            skip_left = skip_left | r.payload_byte;
            cur_phase = (skip_left != 0) ? HDR_INFO_SKIP : ENT_TYPE;
         end
         ENT_INFO_LEN_LO: begin
            skip_left = skip_left | r.payload_byte;
            cur_phase = (skip_left != 0) ? ENT_INFO_SKIP : ENT_TYPE;
         end
         HDR_INFO_SKIP, ENT_INFO_SKIP: begin
            skip_left = skip_left - 1'b1;
            if (skip_left == 0) cur_phase = ENT_TYPE;
         end
         ENT_TYPE: begin
            entry_wanted = cfg.enable && type_wanted(r.payload_byte);
            cur_phase = ENT_PID_HI;
         end
         ENT_PID_HI: begin
            pid_top = r.payload_byte[4:0];
            cur_phase = ENT_PID_LO;
         end
         ENT_PID_LO: begin
            pid = {pid_top, r.payload_byte};
            if (entry_wanted && !pid_seen[pid]) begin
               pid_seen[pid] = 1'b1;
               found_new = 1'b1;
               o.new_pid_valid = 1'b1;
               o.new_pid = pid;
            end
            entry_wanted = 1'b0;
            cur_phase = ENT_INFO_LEN_HI;
         end
         default: cur_phase = HDR_PCR_LO;
      endcase
      if (r.last_byte) begin
         o.section_done = 1'b1;
         o.any_new = found_new;
         o.truncated = (cur_phase != ENT_TYPE);
         clear_section_state();
      end
      return o;
   endfunction

   function automatic void note_csr_write(logic [CsrIndexWidth-1:0] idx, logic [31:0] wd);
      case (idx)
         CSR_ENABLE: cfg.enable = wd[0];
         CSR_WANT_TELETEXT: cfg.want_teletext = wd[0];
         CSR_WANT_SUBTITLES: cfg.want_subtitles = wd[0];
         CSR_WANT_DSMCC: cfg.want_dsmcc = wd[0];
         default: ;
      endcase
   endfunction

   // directed table rows
   function automatic void add_byte(logic [7:0] b, logic last);
      stim_row_type row;
      row = '{kind: ROW_BYTE, item: '0, index: '0, wdata: '0, checked: 1'b0, rsp: '0};
      row.item.payload_byte = b;
      row.item.last_byte = last;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(logic [7:0] b, logic last, logic nv,
                                       logic [PidWidth-1:0] pid, logic done,
                                       logic any, logic trunc);
      add_byte(b, last);
      directed_rows[$].checked = 1'b1;
      directed_rows[$].rsp.new_pid_valid = nv;
      directed_rows[$].rsp.new_pid = pid;
      directed_rows[$].rsp.section_done = done;
      directed_rows[$].rsp.any_new = any;
      directed_rows[$].rsp.truncated = trunc;
   endfunction

   function automatic void add_csr(logic [CsrIndexWidth-1:0] idx, logic [31:0] wd);
      stim_row_type row;
      row = '{kind: ROW_CSR, item: '0, index: idx, wdata: wd, checked: 1'b0, rsp: '0};
      directed_rows.push_back(row);
   endfunction

   // random section building
   function automatic void push_byte(logic [7:0] b);
      req_type r;
      r.payload_byte = b;
      r.last_byte = 1'b0;
      section_q.push_back(r);
   endfunction

   function automatic int pick_len();
      int pick;
      pick = $urandom_range(0, 399);
      if (pick == 0) return 256 + $urandom_range(0, 3);
      if (pick < 160) return 0;
      if (pick < 360) return $urandom_range(1, 4);
      return $urandom_range(5, 20);
   endfunction

   function automatic void push_len_and_body(int len);
      logic [LenWidth-1:0] len_bits;
      len_bits = len[LenWidth-1:0];
      push_byte({4'($urandom_range(0, 15)), len_bits[11:8]});
      push_byte(len_bits[7:0]);
      repeat (len) push_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 9))
         0, 1, 2: return STREAM_PRIVATE_PES;
         3: return STREAM_DSMCC_A;
         4: return STREAM_DSMCC_B;
         5: return STREAM_DSMCC_C;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [PidWidth-1:0] pick_pid();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return PidWidth'($urandom_range(0, 47));
      if (pick == 5) return PidWidth'(8191 - $urandom_range(0, 15));
      return PidWidth'($urandom_range(0, 8191));
   endfunction

   // one section: mostly well formed, some noise, some cut short
   function automatic void make_section();
      logic [PidWidth-1:0] pid;
      int cut;
      section_q.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else begin
         push_byte(8'($urandom_range(0, 255)));
         push_byte(8'($urandom_range(0, 255)));
         push_len_and_body(pick_len());
         repeat ($urandom_range(0, 4)) begin
            push_byte(pick_type());
            pid = pick_pid();
            push_byte({3'($urandom_range(0, 7)), pid[12:8]});
            push_byte(pid[7:0]);
            push_len_and_body(pick_len());
         end
      end
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, section_q.size());
         while (section_q.size() > cut) void'(section_q.pop_back());
      end
      section_q[$].last_byte = 1'b1;
   endfunction

   // one byte transfer on the request side, called just after a falling edge
   task automatic send_item(req_type r, logic checked, rsp_type typed_rsp);
      rsp_type predicted;
      if (!quiet_tail && steady_items == 0 && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end else if (steady_items == 0 && $urandom_range(0, 49) == 0) begin
         steady_items = 30;
      end
      if (steady_items > 0) steady_items--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = parse_pmt_byte(r);
      awaited_rsp.push_back(checked ? typed_rsp : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [31:0] wd);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= wd;
      do @(posedge clock); while (!csr_ready);
      note_csr_write(idx, wd);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_flag(logic [CsrIndexWidth-1:0] idx, logic flag);
      logic [31:0] wd;
      wd = $urandom;
      wd[0] = flag;
      write_csr(idx, wd);
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            rsp_ready <= 1'b1;
            rsp_hold_req = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 99) == 0) begin
            repeat (60) @(negedge clock);
         end
      end
   end

   task automatic check_field(string name, logic [PidWidth-1:0] want_v,
                              logic [PidWidth-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         error_count++;
      end
   endtask

   // result checking against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("new_pid_valid", want.new_pid_valid, rsp_data.new_pid_valid);
            check_field("new_pid", want.new_pid, rsp_data.new_pid);
            check_field("section_done", want.section_done, rsp_data.section_done);
            check_field("any_new", want.any_new, rsp_data.any_new);
            check_field("truncated", want.truncated, rsp_data.truncated);
         end
      end
   end

   // watchdog on cycles with no transfer at all
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      int phase_no;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg.enable = 1'b1;
      cfg.want_teletext = 1'b0;
      cfg.want_subtitles = 1'b0;
      cfg.want_dsmcc = 1'b0;
      clear_section_state();

      // lone byte ends the section inside the pcr pid
      add_checked(8'hFF, 1'b1, 1'b0, '0, 1'b1, 1'b0, 1'b1);
      add_csr(CSR_WANT_TELETEXT, 32'd1);
      add_csr(CSR_WANT_DSMCC, 32'd1);
      // header with one descriptor byte, private pes entry at the top pid
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hF0, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h5A, 1'b0);
      add_byte(STREAM_PRIVATE_PES, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_checked(8'hFF, 1'b0, 1'b1, 13'h1FFF, 1'b0, 1'b0, 1'b0);
      add_byte(8'hF0, 1'b0);
      add_byte(8'h00, 1'b0);
      // dsmcc entry at pid zero, section cut right after its pid
      add_byte(STREAM_DSMCC_C, 1'b0);
      add_byte(8'hE0, 1'b0);
      add_checked(8'h00, 1'b1, 1'b1, '0, 1'b1, 1'b1, 1'b1);
      // out-of-range index must not alias onto a real register
      add_csr(8'hFF, 32'd0);
      // zero info length, selection made on the type byte survives a disable
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(STREAM_DSMCC_A, 1'b0);
      add_csr(CSR_ENABLE, 32'hFFFF_FFFE);
      add_byte(8'h1F, 1'b0);
      add_byte(8'h00, 1'b1);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].checked, directed_rows[i].rsp);
         end
      end

      // random phases, registers rewritten between them with the block idle
      phase_no = 0;
      while (items_sent < ItemTarget) begin
         wait_drained();
         case (phase_no)
            0: begin
               write_flag(CSR_ENABLE, 1'b1);
               write_flag(CSR_WANT_TELETEXT, 1'b1);
               write_flag(CSR_WANT_SUBTITLES, 1'b1);
               write_flag(CSR_WANT_DSMCC, 1'b1);
            end
            1: begin
               write_flag(CSR_ENABLE, 1'b0);
               write_flag(CSR_WANT_TELETEXT, 1'b0);
               write_flag(CSR_WANT_SUBTITLES, 1'b0);
               write_flag(CSR_WANT_DSMCC, 1'b0);
            end
            2: begin
               write_flag(CSR_ENABLE, 1'b1);
               write_flag(CSR_WANT_TELETEXT, 1'b0);
               write_flag(CSR_WANT_SUBTITLES, 1'b1);
               write_flag(CSR_WANT_DSMCC, 1'b0);
            end
            default: begin
               write_flag(CSR_ENABLE, $urandom_range(0, 3) != 0);
               write_flag(CSR_WANT_TELETEXT, 1'($urandom_range(0, 1)));
               write_flag(CSR_WANT_SUBTITLES, 1'($urandom_range(0, 1)));
               write_flag(CSR_WANT_DSMCC, 1'($urandom_range(0, 1)));
            end
         endcase
         if ($urandom_range(0, 2) == 0)
            write_csr(CsrIndexWidth'($urandom_range(4, 255)), $urandom);
         // long receiver hold-off while the sender keeps offering bytes
         if (phase_no == 3) begin
            rsp_hold_req = 1'b1;
            steady_items = 40;
         end
         repeat ($urandom_range(3, 8)) begin
            make_section();
            foreach (section_q[i]) begin
               if (items_sent >= ItemTarget - QuietItems) quiet_tail = 1'b1;
               send_item(section_q[i], 1'b0, '0);
            end
         end
         phase_no++;
      end

      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pspc_pkg.sv
rtl/pspc_front.sv
rtl/pspc_queue.sv
rtl/pspc_back.sv
rtl/pmt_stream_pid_collector.sv
test/pmt_stream_pid_collector_tb.sv
